>>> rtl/cfas_pkg.sv
// Package for the CIGAR builder: operation codes, request records and the
// splice-site consensus test. It depends on nothing else.
package cfas_pkg;

  typedef enum logic [2:0] {
    OP_M = 3'd0,
    OP_I = 3'd1,
    OP_D = 3'd2,
    OP_N = 3'd3,
    OP_S = 3'd4
  } op_code_t;

  localparam int LEN_WIDTH = 32;
  localparam int SLOTS     = 4;

  typedef struct packed {
    logic [LEN_WIDTH-1:0] len;
    op_code_t             code;
  } op_t;

  typedef struct packed {
    logic [SLOTS-1:0] mask;
    op_t [SLOTS-1:0]  ops;
  } seg_rec_t;

  typedef struct packed {
    logic     valid;
    seg_rec_t rec;
  } q_head_t;

  localparam logic [7:0] ASC_A = 8'h41;
  localparam logic [7:0] ASC_C = 8'h43;
  localparam logic [7:0] ASC_G = 8'h47;
  localparam logic [7:0] ASC_T = 8'h54;
  localparam logic [7:0] ASC_N = 8'h4E;

  localparam logic [15:0] DI_GT = {ASC_G, ASC_T};
  localparam logic [15:0] DI_GC = {ASC_G, ASC_C};
  localparam logic [15:0] DI_AG = {ASC_A, ASC_G};
  localparam logic [15:0] DI_CT = {ASC_C, ASC_T};
  localparam logic [15:0] DI_AC = {ASC_A, ASC_C};

  function automatic logic [7:0] base_comp(input logic [7:0] b);
    case (b)
      ASC_A:   return ASC_T;
      ASC_T:   return ASC_A;
      ASC_C:   return ASC_G;
      ASC_G:   return ASC_C;
      default: return ASC_N;
    endcase
  endfunction

  function automatic logic [15:0] revcomp_pair(input logic [15:0] d);
    return {base_comp(d[7:0]), base_comp(d[15:8])};
  endfunction

  function automatic logic is_intron(input logic [15:0] left, input logic [15:0] right,
                                     input logic minus);
    logic [15:0] l;
    logic [15:0] r;
    l = minus ? revcomp_pair(right) : left;
    r = minus ? revcomp_pair(left) : right;
    return ((l == DI_GT || l == DI_GC) && r == DI_AG) || (l == DI_CT && r == DI_AC);
  endfunction

endpackage

>>> rtl/cfas_front.sv
// Front end: accepts segments, keeps the previous segment's ends and builds
// the record of operations that the segment causes. Uses cfas_pkg.
module cfas_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [31:0]       in_genome_start,
  input  logic [31:0]       in_genome_end,
  input  logic [31:0]       in_query_start,
  input  logic [31:0]       in_query_end,
  input  logic              in_first_segment,
  input  logic              in_last_segment,
  input  logic [31:0]       in_read_len,
  input  logic              in_splice_check,
  input  logic              in_minus_strand,
  input  logic [15:0]       in_left_bases,
  input  logic [15:0]       in_right_bases,
  input  logic              q_full,
  output logic              push,
  output cfas_pkg::seg_rec_t rec
);

  localparam int CW = COORD_WIDTH;

  logic [CW-1:0] gs, ge, qs, qe, rlen;
  logic [CW-1:0] prev_ge_r, prev_ge_nxt;
  logic [CW-1:0] prev_qe_r, prev_qe_nxt;
  logic [CW-1:0] g_diff, q_diff, qs_m1, m_len, tail;

  assign gs   = CW'(in_genome_start);
  assign ge   = CW'(in_genome_end);
  assign qs   = CW'(in_query_start);
  assign qe   = CW'(in_query_end);
  assign rlen = CW'(in_read_len);

  assign g_diff = gs - prev_ge_r;
  assign q_diff = qs - prev_qe_r;
  assign qs_m1  = qs - CW'(1);
  assign m_len  = ge - gs + CW'(1);
  assign tail   = rlen - qe;

  assign push = in_valid && !q_full;

  always_comb begin
    rec = '0;
    if (in_first_segment) begin
      rec.mask[0]     = qs > CW'(1);
      rec.ops[0].len  = cfas_pkg::LEN_WIDTH'(qs_m1);
      rec.ops[0].code = cfas_pkg::OP_S;
    end else begin
      rec.mask[0]     = (gs > prev_ge_r) && (g_diff > CW'(1));
      rec.ops[0].len  = cfas_pkg::LEN_WIDTH'(g_diff - CW'(1));
      rec.ops[0].code = (in_splice_check &&
                         cfas_pkg::is_intron(in_left_bases, in_right_bases,
                                             in_minus_strand)) ?
                        cfas_pkg::OP_N : cfas_pkg::OP_D;
    end
    rec.mask[1]     = !in_first_segment && (qs > prev_qe_r) && (q_diff > CW'(1));
    rec.ops[1].len  = cfas_pkg::LEN_WIDTH'(q_diff - CW'(1));
    rec.ops[1].code = cfas_pkg::OP_I;
    rec.mask[2]     = 1'b1;
    rec.ops[2].len  = cfas_pkg::LEN_WIDTH'(m_len);
    rec.ops[2].code = cfas_pkg::OP_M;
    rec.mask[3]     = in_last_segment && (qe < rlen);
    rec.ops[3].len  = cfas_pkg::LEN_WIDTH'(tail);
    rec.ops[3].code = cfas_pkg::OP_S;
  end

  always_comb begin
    prev_ge_nxt = prev_ge_r;
    prev_qe_nxt = prev_qe_r;
    if (push) begin
      prev_ge_nxt = ge;
      prev_qe_nxt = qe;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ge_r <= '0;
      prev_qe_r <= '0;
    end else begin
      prev_ge_r <= prev_ge_nxt;
      prev_qe_r <= prev_qe_nxt;
    end
  end

endmodule

>>> rtl/cfas_queue.sv
// Two-entry queue of segment records between the front and back ends.
// Uses cfas_pkg.
module cfas_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cfas_pkg::seg_rec_t rec,
  input  logic               pop,
  output logic               full,
  output cfas_pkg::q_head_t  head
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  cfas_pkg::seg_rec_t entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  assign full       = count_r == CNTW'(DEPTH);
  assign head.valid = count_r != '0;
  assign head.rec   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CNTW'(push) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/cfas_back.sv
// Back end: walks the head record's operations one per cycle, while the
// result side is not stalled, into the result register. Uses cfas_pkg.
module cfas_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cfas_pkg::q_head_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_op_length,
  output logic [2:0]        out_op_code,
  output logic              out_last_of_segment
);

  logic [cfas_pkg::SLOTS-1:0] done_r, done_nxt;
  logic [cfas_pkg::SLOTS-1:0] pend, sel_bit, rest;
  logic [1:0]                 sel;
  logic                       adv, take;
  logic                       out_valid_r, out_valid_nxt;
  logic [31:0]                out_len_r;
  cfas_pkg::op_code_t         out_code_r;
  logic                       out_last_r;

  assign pend = head.rec.mask & ~done_r;

  always_comb begin
    sel = '0;
    for (int i = cfas_pkg::SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = 2'(i);
      end
    end
  end

  assign sel_bit = cfas_pkg::SLOTS'(1) << sel;
  assign rest    = pend & ~sel_bit;
  assign adv     = !out_valid_r || !out_stall;
  assign take    = head.valid && adv;
  assign pop     = take && (rest == '0);

  always_comb begin
    done_nxt      = done_r;
    out_valid_nxt = adv ? 1'b0 : out_valid_r;
    if (take) begin
      done_nxt      = pop ? '0 : (done_r | sel_bit);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_len_r  <= head.rec.ops[sel].len;
      out_code_r <= head.rec.ops[sel].code;
      out_last_r <= rest == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_op_length       = out_len_r;
  assign out_op_code         = out_code_r;
  assign out_last_of_segment = out_last_r;

endmodule

>>> rtl/cigar_from_aligned_segments_unit.sv
// Top level of the CIGAR builder: front end, record queue and back end.
// Depends on cfas_pkg, cfas_front, cfas_queue and cfas_back.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   one aligned segment
//   out_     output     out_valid / out_stall one CIGAR operation
//
// A segment causes one to four operations, and the back end sends one per
// cycle while the result side is not stalled.
// The front end takes a segment each cycle while the two-entry queue has room.
// The first operation passes through the queue entry and then the result register to the result port.
// Reset clears the previous genome and query ends to zero and empties the queue.
// A stall on the result side holds the result register and fills the queue.
module cigar_from_aligned_segments_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_genome_start,
  input  logic [31:0] in_genome_end,
  input  logic [31:0] in_query_start,
  input  logic [31:0] in_query_end,
  input  logic        in_first_segment,
  input  logic        in_last_segment,
  input  logic [31:0] in_read_len,
  input  logic        in_splice_check,
  input  logic        in_minus_strand,
  input  logic [15:0] in_left_bases,
  input  logic [15:0] in_right_bases,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_op_length,
  output logic [2:0]  out_op_code,
  output logic        out_last_of_segment
);

  logic               push, pop, q_full;
  cfas_pkg::seg_rec_t rec;
  cfas_pkg::q_head_t  q_head;

  assign in_stall = q_full;

  cfas_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_genome_start  (in_genome_start),
    .in_genome_end    (in_genome_end),
    .in_query_start   (in_query_start),
    .in_query_end     (in_query_end),
    .in_first_segment (in_first_segment),
    .in_last_segment  (in_last_segment),
    .in_read_len      (in_read_len),
    .in_splice_check  (in_splice_check),
    .in_minus_strand  (in_minus_strand),
    .in_left_bases    (in_left_bases),
    .in_right_bases   (in_right_bases),
    .q_full           (q_full),
    .push             (push),
    .rec              (rec)
  );

  cfas_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .rec   (rec),
    .pop   (pop),
    .full  (q_full),
    .head  (q_head)
  );

  cfas_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (q_head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_op_length       (out_op_length),
    .out_op_code         (out_op_code),
    .out_last_of_segment (out_last_of_segment)
  );

  a_full_has_head : assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> q_head.valid)
    else $error("queue full without a head request");

  a_last_op_kind : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_segment) |->
      (out_op_code == cfas_pkg::OP_M || out_op_code == cfas_pkg::OP_S))
    else $error("segment closed on an operation other than M or S");

  a_push_fills : assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_head.valid) |=> q_head.valid)
    else $error("request pushed into an empty queue was lost");

  a_pop_needs_head : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_head.valid)
    else $error("queue popped while empty");

endmodule
